// ===== hdl/ddhc_pkg.sv =====
// Package for the differential drive heading control unit.
// Holds codes, constants and the types passed between front, queue and back.
// No dependencies.
package ddhc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int FULL_TURN   = 5760;
  localparam int NEAR_DEG    = 3;
  localparam int WIDE_DEG    = 10;
  localparam int SLOW_RATE   = 20;
  localparam int TRIM_LIMIT  = 32;
  localparam int ARRIVE_DIST = 32;
  localparam int ROUND_HALF  = 8;

  localparam logic [7:0] LEFT_DUTY_RST   = 8'd24;
  localparam logic [7:0] RIGHT_BASE_RST  = 8'd29;
  localparam logic [7:0] RIGHT_MAX_RST   = 8'd29;
  localparam logic [7:0] RIGHT_MIN_RST   = 8'd15;

  typedef enum logic [1:0] {
    CMD_ROTATE   = 2'd0,
    CMD_WAYPOINT = 2'd1,
    CMD_DRIVE    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    LED_NONE   = 2'd0,
    LED_TOGGLE = 2'd1,
    LED_SET    = 2'd2,
    LED_CLEAR  = 2'd3
  } led_e;

  typedef enum logic [1:0] {
    REG_LEFT_DUTY  = 2'd0,
    REG_RIGHT_BASE = 2'd1,
    REG_RIGHT_MAX  = 2'd2,
    REG_RIGHT_MIN  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ROUTE_STOP  = 2'd0,
    ROUTE_CW    = 2'd1,
    ROUTE_CCW   = 2'd2,
    ROUTE_DRIVE = 2'd3
  } route_e;

  typedef enum logic [1:0] {
    SPD_HOLD = 2'd0,
    SPD_ADD  = 2'd1,
    SPD_BASE = 2'd2
  } spd_op_e;

  typedef struct packed {
    route_e             route;
    spd_op_e            spd_op;
    logic signed [11:0] delta;
    led_e               led;
    logic               arrived;
  } ddhc_op_t;

  typedef struct packed {
    logic [7:0] left_duty;
    logic [7:0] right_base;
    logic [7:0] right_max;
    logic [7:0] right_min;
  } ddhc_cfg_t;

  typedef struct packed {
    logic [7:0]  left_forward_pwm;
    logic [7:0]  left_reverse_pwm;
    logic [7:0]  right_forward_pwm;
    logic [7:0]  right_reverse_pwm;
    led_e        led_action;
    logic        arrived;
    logic [15:0] waypoint_index;
  } ddhc_res_t;

endpackage

// ===== hdl/ddhc_if.sv =====
// Channel interfaces for the heading control unit: command ticks in, results out.
// Valid/ready handshake; a beat moves when both are high. No dependencies.
interface ddhc_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [12:0]        current_heading;
  logic [12:0]        target_heading;
  logic signed [15:0] gyro_z_rate;
  logic [15:0]        distance_to_target;

  modport source (output valid, command, current_heading, target_heading, gyro_z_rate,
                  distance_to_target, input ready);
  modport sink (input valid, command, current_heading, target_heading, gyro_z_rate,
                distance_to_target, output ready);
endinterface

interface ddhc_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  left_forward_pwm;
  logic [7:0]  left_reverse_pwm;
  logic [7:0]  right_forward_pwm;
  logic [7:0]  right_reverse_pwm;
  logic [1:0]  led_action;
  logic        arrived;
  logic [15:0] waypoint_index;

  modport source (output valid, left_forward_pwm, left_reverse_pwm, right_forward_pwm,
                  right_reverse_pwm, led_action, arrived, waypoint_index, input ready);
  modport sink (input valid, left_forward_pwm, left_reverse_pwm, right_forward_pwm,
                right_reverse_pwm, led_action, arrived, waypoint_index, output ready);
endinterface

// ===== hdl/differential_drive_heading_control_unit.sv =====
// Differential drive heading control unit: top level with APB register bank.
// A command beat is written into the queue, then moved into the back end's result register;
// one beat per cycle unless res_o.ready stalls. Front classifier, 2-entry queue, registered back end.
// Reset (rst_ni, async low): registers to 24/29/29/15, right speed 29, count 0,
// queue and result register empty. Uses ddhc_pkg, ddhc_if, front, queue and back.
module differential_drive_heading_control_unit
  import ddhc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddhc_cmd_if.sink    cmd_i,
  ddhc_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ddhc_cfg_t cfg_q;
  reg_idx_e  reg_idx;
  logic      cfg_wr;
  logic      push_valid;
  logic      push_ready;
  ddhc_op_t  push_op;
  logic      pop_valid;
  logic      pop_ready;
  ddhc_op_t  pop_op;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_duty  <= LEFT_DUTY_RST;
      cfg_q.right_base <= RIGHT_BASE_RST;
      cfg_q.right_max  <= RIGHT_MAX_RST;
      cfg_q.right_min  <= RIGHT_MIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEFT_DUTY:  cfg_q.left_duty  <= pwdata[7:0];
        REG_RIGHT_BASE: cfg_q.right_base <= pwdata[7:0];
        REG_RIGHT_MAX:  cfg_q.right_max  <= pwdata[7:0];
        REG_RIGHT_MIN:  cfg_q.right_min  <= pwdata[7:0];
        default:        cfg_q.left_duty  <= cfg_q.left_duty;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEFT_DUTY:  prdata = {24'd0, cfg_q.left_duty};
      REG_RIGHT_BASE: prdata = {24'd0, cfg_q.right_base};
      REG_RIGHT_MAX:  prdata = {24'd0, cfg_q.right_max};
      REG_RIGHT_MIN:  prdata = {24'd0, cfg_q.right_min};
      default:        prdata = '0;
    endcase
  end

  ddhc_front u_front (
    .cmd_i        (cmd_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_op_o    (push_op)
  );

  ddhc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  ddhc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .res_o       (res_o)
  );

endmodule

// ===== hdl/ddhc_front.sv =====
// Front end: accepts command beats and classifies them into queue operations.
// Computes heading error, turn direction and speed step. Uses ddhc_pkg, ddhc_cmd_if.
module ddhc_front
  import ddhc_pkg::*;
(
  ddhc_cmd_if.sink   cmd_i,
  input  logic       push_ready_i,
  output logic       push_valid_o,
  output ddhc_op_t   push_op_o
);

  logic [12:0]        cur;
  logic [12:0]        tgt;
  logic [15:0]        gyro_raw;
  logic signed [13:0] diff;
  logic [13:0]        neg_diff;
  logic [12:0]        abs_diff;
  logic [8:0]         abs_coarse;
  logic               aligned;
  logic signed [14:0] cw_raw;
  logic signed [14:0] ccw_raw;
  logic signed [13:0] cw_ang;
  logic signed [13:0] ccw_ang;
  logic               clockwise;
  logic [9:0]         goal;
  logic [15:0]        abs_gyro;
  logic [11:0]        abs_rate;
  logic signed [12:0] rate_err;
  logic signed [12:0] turn_sum;
  logic signed [12:0] turn_rnd;
  logic signed [11:0] turn_step;
  logic [13:0]        round_sum;
  logic [9:0]         trim_mag;
  logic signed [11:0] trim_step;
  spd_op_e            drive_op;
  logic signed [11:0] drive_delta;
  route_e             turn_route;

  function automatic logic signed [13:0] wrap_turn(input logic signed [14:0] x);
    logic signed [14:0] full;
    logic signed [14:0] twice;
    full  = $signed(15'(FULL_TURN));
    twice = $signed(15'(2 * FULL_TURN));
    if (x < 15'sd0) begin
      return $signed(x[13:0]);
    end else if (x >= twice) begin
      return 14'(x - twice);
    end else if (x >= full) begin
      return 14'(x - full);
    end
    return 14'(x);
  endfunction

  assign cur      = cmd_i.current_heading;
  assign tgt      = cmd_i.target_heading;
  assign gyro_raw = cmd_i.gyro_z_rate;

  assign diff       = $signed({1'b0, cur}) - $signed({1'b0, tgt});
  assign neg_diff   = 14'(-diff);
  assign abs_diff   = diff[13] ? neg_diff[12:0] : diff[12:0];
  assign abs_coarse = abs_diff[12:4];
  assign aligned    = abs_coarse <= 9'(NEAR_DEG);

  assign cw_raw    = $signed(15'(FULL_TURN)) - $signed({diff[13], diff});
  assign ccw_raw   = $signed(15'(FULL_TURN)) + $signed({diff[13], diff});
  assign cw_ang    = wrap_turn(cw_raw);
  assign ccw_ang   = wrap_turn(ccw_raw);
  assign clockwise = cw_ang < ccw_ang;

  assign goal      = (abs_coarse > 9'(WIDE_DEG)) ? {abs_coarse, 1'b0} : 10'(SLOW_RATE);
  assign abs_gyro  = gyro_raw[15] ? (~gyro_raw + 16'd1) : gyro_raw;
  assign abs_rate  = abs_gyro[15:4];
  assign rate_err  = $signed({3'b000, goal}) - $signed({1'b0, abs_rate});
  assign turn_sum  = rate_err + (clockwise ? -13'sd2 : 13'sd2);
  assign turn_rnd  = turn_sum[12] ? (turn_sum + 13'sd1) >>> 1 : turn_sum >>> 1;
  assign turn_step = 12'(turn_rnd);
  assign turn_route = clockwise ? ROUTE_CW : ROUTE_CCW;

  assign round_sum = {1'b0, abs_diff} + 14'(ROUND_HALF);
  assign trim_mag  = round_sum[13:4];
  assign trim_step = diff[13] ? $signed({2'b00, trim_mag}) : -$signed({2'b00, trim_mag});

  always_comb begin
    drive_delta = 12'sd0;
    if (diff == 14'sd0) begin
      drive_op = SPD_HOLD;
    end else if (abs_diff >= 13'(TRIM_LIMIT)) begin
      drive_op    = SPD_ADD;
      drive_delta = trim_step;
    end else begin
      drive_op = SPD_BASE;
    end
  end

  always_comb begin
    push_op_o.route   = ROUTE_STOP;
    push_op_o.spd_op  = SPD_HOLD;
    push_op_o.delta   = 12'sd0;
    push_op_o.led     = LED_NONE;
    push_op_o.arrived = 1'b0;
    case (cmd_e'(cmd_i.command))
      CMD_ROTATE: begin
        if (aligned) begin
          push_op_o.led = LED_SET;
        end else begin
          push_op_o.led    = LED_TOGGLE;
          push_op_o.route  = turn_route;
          push_op_o.spd_op = SPD_ADD;
          push_op_o.delta  = turn_step;
        end
      end
      CMD_WAYPOINT: begin
        if (!aligned) begin
          push_op_o.led    = LED_TOGGLE;
          push_op_o.route  = turn_route;
          push_op_o.spd_op = SPD_ADD;
          push_op_o.delta  = turn_step;
        end else if (cmd_i.distance_to_target <= 16'(ARRIVE_DIST)) begin
          push_op_o.led     = LED_CLEAR;
          push_op_o.arrived = 1'b1;
        end else begin
          push_op_o.led    = LED_TOGGLE;
          push_op_o.route  = ROUTE_DRIVE;
          push_op_o.spd_op = drive_op;
          push_op_o.delta  = drive_delta;
        end
      end
      CMD_DRIVE: begin
        push_op_o.route  = ROUTE_DRIVE;
        push_op_o.spd_op = drive_op;
        push_op_o.delta  = drive_delta;
      end
      default: begin
        push_op_o.route = ROUTE_STOP;
      end
    endcase
  end

  assign push_valid_o = cmd_i.valid;
  assign cmd_i.ready  = push_ready_i;

endmodule

// ===== hdl/ddhc_queue.sv =====
// Operation queue between the classifying front end and the executing back end.
// Small register FIFO with occupancy count. Uses ddhc_pkg.
module ddhc_queue
  import ddhc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  ddhc_op_t push_op_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output ddhc_op_t pop_op_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ddhc_op_t        entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not rise on a lone push");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && pop) |=> $stable(count_q))
    else $error("queue count moved on simultaneous push and pop");

endmodule

// ===== hdl/ddhc_back.sv =====
// Back end: executes queued operations, keeps right speed and waypoint count.
// Drives the result register onto the result channel. Uses ddhc_pkg, ddhc_res_if.
module ddhc_back
  import ddhc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ddhc_cfg_t  cfg_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  ddhc_op_t   pop_op_i,
  ddhc_res_if.source res_o
);

  logic               valid_q;
  ddhc_res_t          res_q, res_d;
  logic [7:0]         speed_q, speed_d;
  logic [15:0]        wp_q, wp_d;
  logic               fire;
  logic signed [12:0] sum;
  logic [7:0]         clamped;

  assign pop_ready_o = !valid_q || res_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;

  assign sum = $signed({5'b00000, speed_q}) + $signed({pop_op_i.delta[11], pop_op_i.delta});

  always_comb begin
    if (sum > $signed({5'b00000, cfg_i.right_max})) begin
      clamped = cfg_i.right_max;
    end else if (sum < $signed({5'b00000, cfg_i.right_min})) begin
      clamped = cfg_i.right_min;
    end else begin
      clamped = sum[7:0];
    end
  end

  always_comb begin
    case (pop_op_i.spd_op)
      SPD_ADD:  speed_d = clamped;
      SPD_BASE: speed_d = cfg_i.right_base;
      default:  speed_d = speed_q;
    endcase
    wp_d = wp_q + {15'd0, pop_op_i.arrived};

    res_d.left_forward_pwm  = '0;
    res_d.left_reverse_pwm  = '0;
    res_d.right_forward_pwm = '0;
    res_d.right_reverse_pwm = '0;
    res_d.led_action        = pop_op_i.led;
    res_d.arrived           = pop_op_i.arrived;
    res_d.waypoint_index    = wp_d;
    case (pop_op_i.route)
      ROUTE_CW: begin
        res_d.left_forward_pwm  = cfg_i.left_duty;
        res_d.right_reverse_pwm = speed_d;
      end
      ROUTE_CCW: begin
        res_d.left_reverse_pwm  = cfg_i.left_duty;
        res_d.right_forward_pwm = speed_d;
      end
      ROUTE_DRIVE: begin
        res_d.left_forward_pwm  = cfg_i.left_duty;
        res_d.right_forward_pwm = speed_d;
      end
      default: begin
        res_d.led_action = pop_op_i.led;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      speed_q <= RIGHT_BASE_RST;
      wp_q    <= '0;
    end else begin
      if (fire) begin
        valid_q <= 1'b1;
        speed_q <= speed_d;
        wp_q    <= wp_d;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = valid_q;
  assign res_o.left_forward_pwm  = res_q.left_forward_pwm;
  assign res_o.left_reverse_pwm  = res_q.left_reverse_pwm;
  assign res_o.right_forward_pwm = res_q.right_forward_pwm;
  assign res_o.right_reverse_pwm = res_q.right_reverse_pwm;
  assign res_o.led_action        = res_q.led_action;
  assign res_o.arrived           = res_q.arrived;
  assign res_o.waypoint_index    = res_q.waypoint_index;

  a_arrive_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pop_op_i.arrived) |=> (wp_q == $past(wp_q) + 16'd1))
    else $error("waypoint count did not advance on arrival");

  a_arrive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.arrived) |-> (res_q.led_action == LED_CLEAR &&
      res_q.left_forward_pwm == 8'd0 && res_q.left_reverse_pwm == 8'd0 &&
      res_q.right_forward_pwm == 8'd0 && res_q.right_reverse_pwm == 8'd0))
    else $error("arrival beat with motors running");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> valid_q)
    else $error("popped operation left no result");

endmodule

// ===== verif/testbench.sv =====
// Testbench for differential_drive_heading_control_unit: directed ticks, then random ticks
// over several speed register settings, each beat checked against a table or local predictor.
// Depends on ddhc_pkg, ddhc_cmd_if, ddhc_res_if and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
  import ddhc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_PER_PHASE = 132;
  localparam int PHASES = 7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [12:0]        cur;
    logic [12:0]        tgt;
    logic signed [15:0] gyro;
    logic [15:0]        distance;
  } tick_t;

  typedef struct packed {
    tick_t     tick;
    logic      typed;
    ddhc_res_t want;
  } row_t;

  localparam ddhc_res_t NO_WANT = '0;

  localparam row_t DIRECTED [26] = '{
    '{'{CMD_ROTATE, 13'd100, 13'd100, 16'sd0, 16'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, LED_SET, 1'b0, 16'd0}},
    '{'{CMD_WAYPOINT, 13'd0, 13'd0, 16'sd0, 16'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, LED_CLEAR, 1'b1, 16'd1}},
    '{'{CMD_WAYPOINT, 13'd5759, 13'd5759, 16'sd0, 16'd32}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, LED_CLEAR, 1'b1, 16'd2}},
    '{'{CMD_WAYPOINT, 13'd777, 13'd777, 16'sd0, 16'd33}, 1'b1,
      '{8'd24, 8'd0, 8'd29, 8'd0, LED_TOGGLE, 1'b0, 16'd2}},
    '{'{CMD_UNUSED, 13'd5759, 13'd0, 16'sh8000, 16'hffff}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, LED_NONE, 1'b0, 16'd2}},
    '{'{CMD_DRIVE, 13'd0, 13'd0, 16'sh7fff, 16'd0}, 1'b1,
      '{8'd24, 8'd0, 8'd29, 8'd0, LED_NONE, 1'b0, 16'd2}},
    '{'{CMD_DRIVE, 13'd63, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd31, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd32, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd0, 13'd32, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd0, 13'd31, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd40, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd0, 13'd40, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd0, 13'd5759, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd5759, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd64, 13'd0, 16'sh7fff, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd0, 13'd64, 16'sh8000, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd175, 13'd0, 16'shfff1, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd176, 13'd0, 16'sd17, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd2880, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_WAYPOINT, 13'd1000, 13'd0, 16'sd320, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_WAYPOINT, 13'd0, 13'd63, 16'sd0, 16'hffff}, 1'b0, NO_WANT},
    '{'{CMD_ROTATE, 13'd8191, 13'd0, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_WAYPOINT, 13'd0, 13'd8191, 16'sd0, 16'd100}, 1'b0, NO_WANT},
    '{'{CMD_DRIVE, 13'd8191, 13'd1, 16'sd0, 16'd0}, 1'b0, NO_WANT},
    '{'{CMD_WAYPOINT, 13'd7000, 13'd7000, 16'sd0, 16'd0}, 1'b0, NO_WANT}
  };

  localparam ddhc_cfg_t SPEED_SETS [4] = '{
    '{8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd128, 8'd255, 8'd0},
    '{8'd7, 8'd200, 8'd50, 8'd120}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ddhc_cmd_if cmd_if ();
  ddhc_res_if res_if ();

  differential_drive_heading_control_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ddhc_cfg_t   speed_cfg;
  logic [7:0]  right_duty;
  logic [15:0] waypoints;
  ddhc_res_t   motor_frames [$];
  int          errors = 0;
  int          beats_seen = 0;
  int          arrivals = 0;
  bit          tx_gaps = 1'b0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  int          window_left = 0;
  bit          stalls_on = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] clamp_right(int v);
    if (v > int'(speed_cfg.right_max)) return speed_cfg.right_max;
    if (v < int'(speed_cfg.right_min)) return speed_cfg.right_min;
    return v[7:0];
  endfunction

  function automatic ddhc_res_t steer_tick(tick_t t);
    int cur, tgt, d, coarse, mag, goal, rate, cw, ccw;
    bit aligned, turning, driving, clockwise;
    ddhc_res_t r;
    r = '0;
    turning = 1'b0;
    driving = 1'b0;
    cur = int'(t.cur);
    tgt = int'(t.tgt);
    d = cur - tgt;
    coarse = d / 16;
    mag = coarse < 0 ? -coarse : coarse;
    aligned = mag <= NEAR_DEG;
    case (t.cmd)
      CMD_ROTATE: begin
        r.led_action = aligned ? LED_SET : LED_TOGGLE;
        turning = !aligned;
      end
      CMD_WAYPOINT: begin
        if (!aligned) begin
          r.led_action = LED_TOGGLE;
          turning = 1'b1;
        end else if (t.distance <= ARRIVE_DIST) begin
          r.led_action = LED_CLEAR;
          r.arrived = 1'b1;
          waypoints = waypoints + 16'd1;
        end else begin
          r.led_action = LED_TOGGLE;
          driving = 1'b1;
        end
      end
      CMD_DRIVE: driving = 1'b1;
      default: ;
    endcase
    if (turning) begin
      cw = (tgt - cur + FULL_TURN) % FULL_TURN;
      ccw = (cur - tgt + FULL_TURN) % FULL_TURN;
      clockwise = cw < ccw;
      goal = mag > WIDE_DEG ? 2 * mag : SLOW_RATE;
      rate = int'(t.gyro) / 16;
      if (rate < 0) rate = -rate;
      right_duty = clamp_right(int'(right_duty) + ((clockwise ? -2 : 2) + goal - rate) / 2);
      if (clockwise) begin
        r.left_forward_pwm = speed_cfg.left_duty;
        r.right_reverse_pwm = right_duty;
      end else begin
        r.left_reverse_pwm = speed_cfg.left_duty;
        r.right_forward_pwm = right_duty;
      end
    end
    if (driving) begin
      mag = ((d < 0 ? -d : d) + ROUND_HALF) / 16;
      if (d >= TRIM_LIMIT) right_duty = clamp_right(int'(right_duty) - mag);
      else if (d <= -TRIM_LIMIT) right_duty = clamp_right(int'(right_duty) + mag);
      else if (d != 0) right_duty = speed_cfg.right_base;
      r.left_forward_pwm = speed_cfg.left_duty;
      r.right_forward_pwm = right_duty;
    end
    r.waypoint_index = waypoints;
    return r;
  endfunction

  task automatic send_tick(tick_t t, logic typed, ddhc_res_t want);
    ddhc_res_t predicted;
    cmd_if.valid <= 1'b1;
    cmd_if.command <= t.cmd;
    cmd_if.current_heading <= t.cur;
    cmd_if.target_heading <= t.tgt;
    cmd_if.gyro_z_rate <= t.gyro;
    cmd_if.distance_to_target <= t.distance;
    do @(posedge clk_i); while (!cmd_if.ready);
    predicted = steer_tick(t);
    motor_frames.push_back(typed ? want : predicted);
    if (tx_gaps && !no_idle && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (motor_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_speed_reg(reg_idx_e idx, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LEFT_DUTY:  speed_cfg.left_duty = v;
      REG_RIGHT_BASE: speed_cfg.right_base = v;
      REG_RIGHT_MAX:  speed_cfg.right_max = v;
      default:        speed_cfg.right_min = v;
    endcase
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {24'd0, v}) begin
      $display("%0t: register %s expected %0d, got %0d", $time, idx.name(), v, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (window_left == 0) begin
      window_left = $urandom_range(32, 160);
      stalls_on = $urandom_range(0, 2) != 0;
    end
    window_left--;
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (stalls_on && !no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ddhc_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beats_seen++;
      if (res_if.arrived) arrivals++;
      if (motor_frames.size() == 0) begin
        $display("%0t: result beat with nothing outstanding", $time);
        errors++;
      end else begin
        want = motor_frames.pop_front();
        cmp_field("left_forward_pwm", want.left_forward_pwm, res_if.left_forward_pwm);
        cmp_field("left_reverse_pwm", want.left_reverse_pwm, res_if.left_reverse_pwm);
        cmp_field("right_forward_pwm", want.right_forward_pwm, res_if.right_forward_pwm);
        cmp_field("right_reverse_pwm", want.right_reverse_pwm, res_if.right_reverse_pwm);
        cmp_field("led_action", want.led_action, res_if.led_action);
        cmp_field("arrived", want.arrived, res_if.arrived);
        cmp_field("waypoint_index", want.waypoint_index, res_if.waypoint_index);
      end
    end
  end

  initial begin
    #400000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    tick_t     t;
    ddhc_cfg_t s;
    int        pick;
    int        tg;
    int        g;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    res_if.ready = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_ROTATE;
    cmd_if.current_heading = '0;
    cmd_if.target_heading = '0;
    cmd_if.gyro_z_rate = '0;
    cmd_if.distance_to_target = '0;
    speed_cfg = '{LEFT_DUTY_RST, RIGHT_BASE_RST, RIGHT_MAX_RST, RIGHT_MIN_RST};
    right_duty = RIGHT_BASE_RST;
    waypoints = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gaps = 1'b1;
    foreach (DIRECTED[i]) send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        if (p <= 4) begin
          s = SPEED_SETS[p - 1];
        end else begin
          s.left_duty = 8'($urandom);
          s.right_base = 8'($urandom);
          s.right_max = 8'($urandom_range(100, 255));
          s.right_min = 8'($urandom_range(0, int'(s.right_max)));
        end
        write_speed_reg(REG_LEFT_DUTY, s.left_duty);
        write_speed_reg(REG_RIGHT_BASE, s.right_base);
        write_speed_reg(REG_RIGHT_MAX, s.right_max);
        write_speed_reg(REG_RIGHT_MIN, s.right_min);
      end
      tx_gaps = $urandom_range(0, 3) != 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (p == PHASES - 1 && n == 40) no_idle = 1'b1;
        if (p == 3 && n == 66) drain();
        pick = $urandom_range(0, 19);
        t.cmd = pick < 6 ? CMD_ROTATE : pick < 12 ? CMD_WAYPOINT :
                pick < 19 ? CMD_DRIVE : CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) begin
          t.cur = 13'($urandom);
          t.tgt = 13'($urandom);
        end else begin
          t.cur = 13'($urandom_range(0, FULL_TURN - 1));
          if ($urandom_range(0, 2) == 0) begin
            tg = $urandom_range(0, FULL_TURN - 1);
          end else begin
            tg = int'(t.cur) + int'($urandom_range(0, 400)) - 200;
            if (tg < 0) tg += FULL_TURN;
            if (tg >= FULL_TURN) tg -= FULL_TURN;
          end
          t.tgt = 13'(tg);
        end
        if ($urandom_range(0, 1) == 0) begin
          g = int'($urandom_range(0, 1600)) - 800;
          t.gyro = 16'(g);
        end else begin
          t.gyro = 16'($urandom);
        end
        t.distance = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 64));
        send_tick(t, 1'b0, NO_WANT);
      end
    end
    drain();

    $display("checked %0d result beats over %0d register settings, %0d waypoint arrivals",
             beats_seen, PHASES, arrivals);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
